// ===== hdl/jsu_pkg.sv =====
package jsu_pkg;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_STR  = 3'd1,
        PH_ESC  = 3'd2,
        PH_HEX1 = 3'd3,
        PH_HEX2 = 3'd4,
        PH_HEX3 = 3'd5,
        PH_HEX4 = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        K_DATA   = 2'd0,
        K_DONE   = 2'd1,
        K_BADESC = 2'd2,
        K_UNTERM = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_req;
        logic       end_of_buffer;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        kind_t      kind;
        logic       last;
    } out_word_t;

    localparam int MAX_RESULTS = 3;
    localparam int CNT_W       = 2;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_QMARK = 8'h3F;

    localparam logic [7:0] CTL_BS = 8'h08;
    localparam logic [7:0] CTL_FF = 8'h0C;
    localparam logic [7:0] CTL_LF = 8'h0A;
    localparam logic [7:0] CTL_CR = 8'h0D;
    localparam logic [7:0] CTL_HT = 8'h09;

    // bit 4 set means not a hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] t;
        begin
            t = 8'h00;
            if (c inside {[8'h30:8'h39]})
            begin
                t = c - 8'h30;
                hex_digit = {1'b0, t[3:0]};
            end
            else if (c inside {[8'h61:8'h66]})
            begin
                t = c - 8'h57;
                hex_digit = {1'b0, t[3:0]};
            end
            else if (c inside {[8'h41:8'h46]})
            begin
                t = c - 8'h37;
                hex_digit = {1'b0, t[3:0]};
            end
            else
            begin
                hex_digit = 5'b1_0000;
            end
        end
    endfunction

endpackage

// ===== hdl/jsu_stream_if.sv =====
interface jsu_stream_if #(
    parameter type word_t = logic
);
    logic  valid;
    logic  ready;
    word_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/json_string_unescaper.sv =====
// a word accepted on rx passes the input register, then the result register, before its first result shows on tx
// throughput: one word per cycle while each word gives at most one result and tx is ready
// a word giving n results holds the result register until all n have left on tx
// the input register takes a new word while results still wait on tx
// reset (rst_n low, asynchronous): idle outside any literal, all buffers empty
module json_string_unescaper (
    input logic           clk,
    input logic           rst_n,
    jsu_stream_if.sink    rx,
    jsu_stream_if.source  tx
);
    import jsu_pkg::*;

    logic                 in_valid_reg;
    logic                 in_valid_next;
    in_word_t             in_word_reg;

    phase_t               phase_reg;
    phase_t               phase_next;
    logic [15:0]          code_point_reg;
    logic [15:0]          code_point_next;
    logic                 hex_invalid_reg;
    logic                 hex_invalid_next;

    logic [7:0]           res_byte_reg [MAX_RESULTS];
    logic [7:0]           res_byte_next [MAX_RESULTS];
    kind_t                res_kind_reg [MAX_RESULTS];
    kind_t                res_kind_next [MAX_RESULTS];
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;

    logic [7:0]           new_byte [MAX_RESULTS];
    kind_t                new_kind [MAX_RESULTS];
    logic [CNT_W-1:0]     new_cnt;

    logic                 adv;
    logic                 rx_fire;
    logic                 tx_fire;
    logic [4:0]           digit;
    logic [15:0]          cp_shift;
    logic                 bad_shift;
    logic                 in_literal;
    logic [7:0]           b;

    assign tx_fire = tx.valid && tx.ready;
    assign adv     = in_valid_reg
                     && ((cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && tx.ready));
    assign rx.ready = !in_valid_reg || adv;
    assign rx_fire  = rx.valid && rx.ready;

    assign b          = in_word_reg.data_byte;
    assign digit      = hex_digit(b);
    assign cp_shift   = {code_point_reg[11:0], digit[3:0]};
    assign bad_shift  = hex_invalid_reg | digit[4];
    assign in_literal = phase_reg inside {[PH_STR:PH_HEX4]};

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (rx_fire)
        begin
            in_valid_next = 1'b1;
        end
        else if (adv)
        begin
            in_valid_next = 1'b0;
        end
    end

    // next state
    always_comb
    begin
        phase_next       = phase_reg;
        code_point_next  = code_point_reg;
        hex_invalid_next = hex_invalid_reg;
        if (adv)
        begin
            if (in_word_reg.end_of_buffer)
            begin
                phase_next = PH_IDLE;
            end
            else if (in_word_reg.start_req)
            begin
                phase_next = PH_STR;
            end
            else
            begin
                case (phase_reg)
                    PH_STR:
                    begin
                        if (b == CH_QUOTE)
                        begin
                            phase_next = PH_IDLE;
                        end
                        else if (b == CH_BSL)
                        begin
                            phase_next = PH_ESC;
                        end
                    end
                    PH_ESC:
                    begin
                        if (b inside {CH_QUOTE, CH_BSL, CH_SLASH, CH_B, CH_F, CH_N,
                                      CH_R, CH_T})
                        begin
                            phase_next = PH_STR;
                        end
                        else if (b == CH_U)
                        begin
                            code_point_next  = '0;
                            hex_invalid_next = 1'b0;
                            phase_next       = PH_HEX1;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_HEX1, PH_HEX2, PH_HEX3:
                    begin
                        code_point_next  = cp_shift;
                        hex_invalid_next = bad_shift;
                        phase_next       = phase_t'(phase_reg + 3'd1);
                    end
                    PH_HEX4:
                    begin
                        code_point_next  = cp_shift;
                        hex_invalid_next = bad_shift;
                        phase_next       = PH_STR;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // results of the word in the input register
    always_comb
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            new_byte[i] = '0;
            new_kind[i] = K_DATA;
        end
        new_cnt = '0;
        if (in_word_reg.end_of_buffer)
        begin
            if (in_literal)
            begin
                new_kind[0] = K_UNTERM;
                new_cnt     = CNT_W'(1);
            end
        end
        else if (!in_word_reg.start_req)
        begin
            case (phase_reg)
                PH_STR:
                begin
                    if (b == CH_QUOTE)
                    begin
                        new_kind[0] = K_DONE;
                        new_cnt     = CNT_W'(1);
                    end
                    else if (b != CH_BSL)
                    begin
                        new_byte[0] = b;
                        new_cnt     = CNT_W'(1);
                    end
                end
                PH_ESC:
                begin
                    new_cnt = CNT_W'(1);
                    case (b)
                        CH_QUOTE: new_byte[0] = CH_QUOTE;
                        CH_BSL:   new_byte[0] = CH_BSL;
                        CH_SLASH: new_byte[0] = CH_SLASH;
                        CH_B:     new_byte[0] = CTL_BS;
                        CH_F:     new_byte[0] = CTL_FF;
                        CH_N:     new_byte[0] = CTL_LF;
                        CH_R:     new_byte[0] = CTL_CR;
                        CH_T:     new_byte[0] = CTL_HT;
                        CH_U:     new_cnt     = '0;
                        default:  new_kind[0] = K_BADESC;
                    endcase
                end
                PH_HEX4:
                begin
                    if (bad_shift)
                    begin
                        new_byte[0] = CH_QMARK;
                        new_cnt     = CNT_W'(1);
                    end
                    else if (cp_shift inside {[16'h0000:16'h007F]})
                    begin
                        new_byte[0] = cp_shift[7:0];
                        new_cnt     = CNT_W'(1);
                    end
                    else if (cp_shift inside {[16'h0080:16'h07FF]})
                    begin
                        new_byte[0] = {3'b110, cp_shift[10:6]};
                        new_byte[1] = {2'b10, cp_shift[5:0]};
                        new_cnt     = CNT_W'(2);
                    end
                    else
                    begin
                        new_byte[0] = {4'b1110, cp_shift[15:12]};
                        new_byte[1] = {2'b10, cp_shift[11:6]};
                        new_byte[2] = {2'b10, cp_shift[5:0]};
                        new_cnt     = CNT_W'(3);
                    end
                end
                default:
                begin
                    new_cnt = '0;
                end
            endcase
        end
    end

    // result register: load on advance, shift on each tx word
    always_comb
    begin
        res_byte_next = res_byte_reg;
        res_kind_next = res_kind_reg;
        cnt_next      = cnt_reg;
        if (adv)
        begin
            res_byte_next = new_byte;
            res_kind_next = new_kind;
            cnt_next      = new_cnt;
        end
        else if (tx_fire)
        begin
            for (int i = 0; i < MAX_RESULTS - 1; i++)
            begin
                res_byte_next[i] = res_byte_reg[i+1];
                res_kind_next[i] = res_kind_reg[i+1];
            end
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            phase_reg       <= PH_IDLE;
            code_point_reg  <= '0;
            hex_invalid_reg <= 1'b0;
            cnt_reg         <= '0;
        end
        else
        begin
            in_valid_reg    <= in_valid_next;
            phase_reg       <= phase_next;
            code_point_reg  <= code_point_next;
            hex_invalid_reg <= hex_invalid_next;
            cnt_reg         <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_fire)
        begin
            in_word_reg <= rx.payload;
        end
        res_byte_reg <= res_byte_next;
        res_kind_reg <= res_kind_next;
    end

    assign tx.valid            = (cnt_reg != '0);
    assign tx.payload.out_byte = res_byte_reg[0];
    assign tx.payload.kind     = res_kind_reg[0];
    assign tx.payload.last     = (cnt_reg == CNT_W'(1));

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_RESULTS))
        else $error("result count out of range");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        adv |-> ((cnt_reg == '0) || tx_fire))
        else $error("results overwritten before delivery");

    a_status_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (tx.valid && (res_kind_reg[0] != K_DATA))
        |-> ((res_byte_reg[0] == 8'h00) && (cnt_reg == CNT_W'(1))))
        else $error("status result not a lone zero word");

    a_eob_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && in_word_reg.end_of_buffer) |=> (phase_reg == PH_IDLE))
        else $error("end of buffer did not return to idle");

    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !adv) |=> (in_valid_reg && $stable(in_word_reg)))
        else $error("pending input word lost");
`endif

endmodule
